FILE: src/echo_distance_median_filter_top_macros.svh
// assertion macros of the echo distance median filter checker
`ifndef ECHO_DISTANCE_MEDIAN_FILTER_TOP_MACROS_SVH
`define ECHO_DISTANCE_MEDIAN_FILTER_TOP_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define EDMF_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("edmf assertion failed");

// concurrent assertion on the usual clock and reset names
`define EDMF_ASSERT(lbl, prop) `EDMF_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: src/edmf_pkg.sv
// shared constants and types of the echo distance median filter
`default_nettype none

package edmf_pkg;

  // window geometry
  localparam int unsigned WINDOW_SIZE = 5;
  localparam int unsigned IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned HALF        = WINDOW_SIZE / 2;
  localparam bit          WINDOW_ODD  = (WINDOW_SIZE % 2) == 1;

  // field widths
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned REM_W   = 15;

  // conversion constants
  localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd343;
  localparam logic [TIME_W-1:0]  ROUND_ADD   = 32'd10000;
  localparam logic [REM_W:0]     DIVISOR     = 16'd20000;

  // division by 20000 as a shift by 5 and a multiply by the rounded-up 2^37 / 625,
  // exact for every 27-bit shifted dividend
  localparam int unsigned            DIV_PRE_SHIFT   = 5;
  localparam int unsigned            DIV_RECIP_W     = 28;
  localparam int unsigned            DIV_RECIP_SHIFT = 37;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP       = 28'd219902326;
  localparam int unsigned            MUL_W           = TIME_W + DIV_RECIP_W;

  // operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef logic [DIST_W-1:0] dist_t;

  // top to window control
  typedef struct packed {
    logic push;
    logic restart;
  } win_ctrl_t;

  // window status back to top
  typedef struct packed {
    logic busy;
    logic full;
  } win_stat_t;

endpackage

`default_nettype wire

FILE: src/edmf_if.sv
// valid/ready channels for echo captures and filter results
`default_nettype none

interface edmf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [edmf_pkg::TICK_W-1:0]   echo_start_tick;
  logic [edmf_pkg::TICK_W-1:0]   echo_end_tick;
  logic [edmf_pkg::TICK_W-1:0]   overflow_count;

  modport source (output valid, output op, output echo_start_tick,
                  output echo_end_tick, output overflow_count, input ready);
  modport sink   (input valid, input op, input echo_start_tick,
                  input echo_end_tick, input overflow_count, output ready);
endinterface

interface edmf_out_if;
  logic                          valid;
  logic                          ready;
  logic [edmf_pkg::DIST_W-1:0]   sample_distance_cm;
  logic [edmf_pkg::DIST_W-1:0]   median_cm;
  logic                          median_ready;

  modport source (output valid, output sample_distance_cm, output median_cm,
                  output median_ready, input ready);
  modport sink   (input valid, input sample_distance_cm, input median_cm,
                  input median_ready, output ready);
endinterface

`default_nettype wire

FILE: src/edmf_dist.sv
// echo time to distance conversion on one shared adder and one shared multiplier
`default_nettype none

module edmf_dist (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [edmf_pkg::TICK_W-1:0]   start_tick_i,
  input  wire logic [edmf_pkg::TICK_W-1:0]   end_tick_i,
  input  wire logic [edmf_pkg::TICK_W-1:0]   ovf_i,
  input  wire logic [edmf_pkg::SPEED_W-1:0]  speed_i,
  output logic                               done_o,
  output edmf_pkg::dist_t                    dist_o
);

  typedef enum logic [2:0] {
    D_IDLE, D_T1, D_T2, D_T3, D_MUL, D_RND, D_DIV, D_FIN
  } dist_state_e;

  dist_state_e                         state_q;
  logic [edmf_pkg::TIME_W-1:0]         acc_q, acc_d;
  logic [edmf_pkg::TICK_W-1:0]         start_q, end_q, ovf_q;

  logic [edmf_pkg::TIME_W-1:0]         add_b;
  logic                                add_sub;
  logic [edmf_pkg::TIME_W-1:0]         add_sum;
  logic [edmf_pkg::TIME_W-1:0]         mul_a;
  logic [edmf_pkg::DIV_RECIP_W-1:0]    mul_b;
  logic [edmf_pkg::MUL_W-1:0]          prod;

  // shared adder operand select
  always_comb begin
    add_b   = edmf_pkg::ROUND_ADD;
    add_sub = 1'b0;
    case (state_q)
      D_T1: begin
        add_b   = edmf_pkg::TIME_W'(ovf_q);
        add_sub = 1'b1;
      end
      D_T2: begin
        add_b   = edmf_pkg::TIME_W'(end_q);
        add_sub = 1'b0;
      end
      D_T3: begin
        add_b   = edmf_pkg::TIME_W'(start_q);
        add_sub = 1'b1;
      end
      default: begin
        add_b   = edmf_pkg::ROUND_ADD;
        add_sub = 1'b0;
      end
    endcase
    add_sum = acc_q + (add_sub ? ~add_b : add_b) + edmf_pkg::TIME_W'(add_sub);
  end

  // shared multiplier: time times speed, then the reciprocal of the divisor
  always_comb begin
    mul_a = acc_q;
    mul_b = edmf_pkg::DIV_RECIP_W'(speed_i);
    if (state_q == D_DIV) begin
      mul_a = edmf_pkg::TIME_W'(acc_q[edmf_pkg::TIME_W-1:edmf_pkg::DIV_PRE_SHIFT]);
      mul_b = edmf_pkg::DIV_RECIP;
    end
    prod = edmf_pkg::MUL_W'(mul_a) * edmf_pkg::MUL_W'(mul_b);
  end

  // accumulator next value per step
  always_comb begin
    acc_d = acc_q;
    case (state_q)
      D_T1, D_T2, D_T3: acc_d = add_sum;
      D_MUL:            acc_d = prod[edmf_pkg::TIME_W-1:0];
      D_RND:            acc_d = add_sum;
      D_DIV:            acc_d = edmf_pkg::TIME_W'(
                                  prod[edmf_pkg::DIV_RECIP_SHIFT +: edmf_pkg::DIST_W]);
      default:          acc_d = acc_q;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      case (state_q)
        D_IDLE: if (start_i) state_q <= D_T1;
        D_T1:    state_q <= D_T2;
        D_T2:    state_q <= D_T3;
        D_T3:    state_q <= D_MUL;
        D_MUL:   state_q <= D_RND;
        D_RND:   state_q <= D_DIV;
        D_DIV:   state_q <= D_FIN;
        D_FIN:   state_q <= D_IDLE;
        default: state_q <= D_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      start_q <= start_tick_i;
      end_q   <= end_tick_i;
      ovf_q   <= ovf_i;
      acc_q   <= {ovf_i, {edmf_pkg::TICK_W{1'b0}}};
    end else begin
      acc_q <= acc_d;
    end
  end

  assign done_o = (state_q == D_FIN);
  assign dist_o = acc_q[edmf_pkg::DIST_W-1:0];

endmodule

`default_nettype wire

FILE: src/edmf_window.sv
// distance window store with rank scan median
`default_nettype none

module edmf_window (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  edmf_pkg::win_ctrl_t       ctrl_i,
  input  edmf_pkg::dist_t           dist_i,
  output edmf_pkg::win_stat_t       stat_o,
  output edmf_pkg::dist_t           median_o
);

  typedef enum logic [1:0] {W_IDLE, W_SCAN, W_AVG} win_state_e;

  win_state_e                      state_q;
  edmf_pkg::dist_t                 win_q [edmf_pkg::WINDOW_SIZE];
  logic [edmf_pkg::IDX_W-1:0]      count_q;
  logic [edmf_pkg::IDX_W-1:0]      idx_q;
  logic                            full_q;
  edmf_pkg::dist_t                 median_q;
  edmf_pkg::dist_t                 mid_lo_q, mid_hi_q;

  edmf_pkg::dist_t                 cand;
  logic [edmf_pkg::IDX_W-1:0]      rank;
  logic [edmf_pkg::DIST_W:0]       mid_sum;

  // stable rank of the candidate entry against the whole window
  always_comb begin
    cand = win_q[idx_q];
    rank = '0;
    for (int j = 0; j < edmf_pkg::WINDOW_SIZE; j++) begin
      if (win_q[j] < cand || (win_q[j] == cand && edmf_pkg::IDX_W'(j) < idx_q)) begin
        rank = rank + edmf_pkg::IDX_W'(1);
      end
    end
  end

  assign mid_sum = {1'b0, mid_lo_q} + {1'b0, mid_hi_q};

  // window entries
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && ctrl_i.push && !ctrl_i.restart) begin
      win_q[count_q] <= dist_i;
    end
  end

  // sequencer, fill count and median
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= W_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      full_q   <= 1'b0;
      median_q <= '0;
      mid_lo_q <= '0;
      mid_hi_q <= '0;
    end else if (ctrl_i.restart) begin
      state_q  <= W_IDLE;
      count_q  <= '0;
      full_q   <= 1'b0;
      median_q <= '0;
    end else begin
      case (state_q)
        W_IDLE: begin
          if (ctrl_i.push) begin
            if (count_q == edmf_pkg::IDX_W'(edmf_pkg::WINDOW_SIZE - 1)) begin
              count_q <= '0;
              idx_q   <= '0;
              full_q  <= 1'b1;
              state_q <= W_SCAN;
            end else begin
              count_q <= count_q + 1'b1;
              full_q  <= 1'b0;
            end
          end
        end
        W_SCAN: begin
          if (rank == edmf_pkg::IDX_W'(edmf_pkg::HALF)) mid_hi_q <= cand;
          if (!edmf_pkg::WINDOW_ODD && rank == edmf_pkg::IDX_W'(edmf_pkg::HALF - 1)) begin
            mid_lo_q <= cand;
          end
          if (idx_q == edmf_pkg::IDX_W'(edmf_pkg::WINDOW_SIZE - 1)) begin
            state_q <= W_AVG;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        W_AVG: begin
          median_q <= edmf_pkg::WINDOW_ODD ? mid_hi_q : mid_sum[edmf_pkg::DIST_W:1];
          state_q  <= W_IDLE;
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != W_IDLE);
  assign stat_o.full = full_q;
  assign median_o    = median_q;

endmodule

`default_nettype wire

FILE: src/echo_distance_median_filter_top.sv
// Echo distance median filter, top level.
// Usage: echo captures enter on in_i (valid/ready); a transfer with op = 0 carries
// start tick, end tick and overflow count, op = 1 restarts the window and clears
// the median. Each input transfer yields exactly one result transfer on out_o:
// the sample distance, the median of the last completed window and a flag that
// is high when this capture completed a window of WINDOW_SIZE entries.
// The speed of sound register is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, and the block itself does not enforce this.
// Steps: a capture passes three adder steps for the echo time, the speed multiply,
// the rounding add, one reciprocal multiply for the division by 20000, a finish state,
// the window push and the hand-off to the output register; a capture that completes
// the window also waits for the rank scan. A restart goes straight to the hand-off.
// Throughput: one item at a time; in_i.ready is high only while no item is in work.
// The result sits in an output register, so the next item is taken while it waits.
// If out_o.ready stays low, the finished next result waits until the register is free.
// Reset: speed 343 m/s, empty window, median 0, no result pending.
`default_nettype none

module echo_distance_median_filter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [edmf_pkg::SPEED_W-1:0]  cfg_wdata_i,
  edmf_in_if.sink                            in_i,
  edmf_out_if.source                         out_o
);

  typedef enum logic [1:0] {S_IDLE, S_DIST, S_WIN, S_DONE} top_state_e;

  top_state_e                    state_q;
  logic [edmf_pkg::SPEED_W-1:0]  speed_q;
  edmf_pkg::dist_t               res_dist_q;
  logic                          res_ready_q;
  logic                          out_valid_q;
  edmf_pkg::dist_t               out_dist_q, out_median_q;
  logic                          out_flag_q;

  logic                          in_fire;
  logic                          dist_done;
  edmf_pkg::dist_t               conv_dist;
  edmf_pkg::win_ctrl_t           win_ctrl;
  edmf_pkg::win_stat_t           win_stat;
  edmf_pkg::dist_t               win_median;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // speed of sound register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= edmf_pkg::SPEED_RESET;
    end else if (cfg_we_i) begin
      speed_q <= cfg_wdata_i;
    end
  end

  // distance conversion
  edmf_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_fire && in_i.op == edmf_pkg::OP_SAMPLE),
    .start_tick_i (in_i.echo_start_tick),
    .end_tick_i   (in_i.echo_end_tick),
    .ovf_i        (in_i.overflow_count),
    .speed_i      (speed_q),
    .done_o       (dist_done),
    .dist_o       (conv_dist)
  );

  // window control
  assign win_ctrl.push    = (state_q == S_DIST) && dist_done;
  assign win_ctrl.restart = in_fire && (in_i.op == edmf_pkg::OP_RESTART);

  edmf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .dist_i   (conv_dist),
    .stat_o   (win_stat),
    .median_o (win_median)
  );

  // item sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_dist_q   <= '0;
      res_ready_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_dist_q   <= '0;
      out_median_q <= '0;
      out_flag_q   <= 1'b0;
    end else begin
      // drop a taken result unless a new one loads in this cycle
      if (out_valid_q && out_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.op == edmf_pkg::OP_RESTART) begin
              res_dist_q  <= '0;
              res_ready_q <= 1'b0;
              state_q     <= S_DONE;
            end else begin
              state_q <= S_DIST;
            end
          end
        end
        S_DIST: begin
          if (dist_done) begin
            res_dist_q <= conv_dist;
            state_q    <= S_WIN;
          end
        end
        S_WIN: begin
          if (!win_stat.busy) begin
            res_ready_q <= win_stat.full;
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_dist_q   <= res_dist_q;
            out_median_q <= win_median;
            out_flag_q   <= res_ready_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.sample_distance_cm = out_dist_q;
  assign out_o.median_cm          = out_median_q;
  assign out_o.median_ready       = out_flag_q;

endmodule

`default_nettype wire

FILE: src/edmf_checker.sv
// port level checks of the echo distance median filter and their binding
`default_nettype none

`include "echo_distance_median_filter_top_macros.svh"

module edmf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [edmf_pkg::DIST_W-1:0] out_dist_i,
  input wire logic [edmf_pkg::DIST_W-1:0] out_median_i,
  input wire logic                        out_flag_i
);

  // an accepted item keeps the block busy in the following cycle
  `EDMF_ASSERT(a_busy_after_transfer, in_valid_i && in_ready_i |=> !in_ready_i)

  // a stalled result holds its payload
  `EDMF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_dist_i) && $stable(out_median_i) && $stable(out_flag_i))

  // distances never exceed the largest 32-bit quotient
  `EDMF_ASSERT(a_dist_range, out_valid_i |-> out_dist_i <= 18'd214748 && out_median_i <= 18'd214748)

endmodule

bind echo_distance_median_filter_top edmf_checker u_edmf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_dist_i   (out_o.sample_distance_cm),
  .out_median_i (out_o.median_cm),
  .out_flag_i   (out_o.median_ready)
);

`default_nettype wire

FILE: test/edmf_result_checker.sv
`timescale 1ns / 100ps
// result checker for the echo distance median filter: tracks the window and compares each result
module edmf_result_checker
  import edmf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SPEED_W-1:0] cfg_wdata_i,
  edmf_in_if                 in_i,
  edmf_out_if                res_i,
  output int unsigned        fail_count_o,
  output int unsigned        outstanding_o
);

  localparam logic [TIME_W-1:0] TICK_WRAP = 32'hFFFF;

  typedef struct packed {
    dist_t distance;
    dist_t median;
    logic  ready;
  } filter_result_t;

  // own copy of the filter state
  logic [SPEED_W-1:0] speed_q;
  dist_t              window_q [WINDOW_SIZE];
  int unsigned        fill_q;
  dist_t              median_q;

  filter_result_t expected_results[$];
  int unsigned    fail_count = 0;
  int unsigned    outstanding = 0;

  assign fail_count_o  = fail_count;
  assign outstanding_o = outstanding;

  // round trip time to centimetres, all modulo 2^32
  function automatic dist_t capture_distance(input logic [TICK_W-1:0] start_tick,
                                             input logic [TICK_W-1:0] stop_tick,
                                             input logic [TICK_W-1:0] wraps,
                                             input logic [SPEED_W-1:0] speed);
    logic [TIME_W-1:0] round_trip;
    logic [TIME_W-1:0] scaled;
    logic [TIME_W-1:0] quotient;
    round_trip = {16'd0, stop_tick} + {16'd0, wraps} * TICK_WRAP - {16'd0, start_tick};
    scaled     = round_trip * {22'd0, speed} + ROUND_ADD;
    quotient   = scaled / {16'd0, DIVISOR};
    return quotient[DIST_W-1:0];
  endfunction

  // median of the full window, lower-rounded mean of the middle pair for even sizes
  function automatic dist_t window_median();
    dist_t           sorted [WINDOW_SIZE];
    dist_t           key;
    int              i;
    int              j;
    logic [DIST_W:0] pair_sum;
    for (i = 0; i < WINDOW_SIZE; i++) sorted[i] = window_q[i];
    for (i = 1; i < WINDOW_SIZE; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    if (WINDOW_ODD) return sorted[HALF];
    pair_sum = {1'b0, sorted[HALF-1]} + {1'b0, sorted[HALF]};
    return pair_sum[DIST_W:1];
  endfunction

  // advance the window by one accepted item and form its result
  task automatic predict_filter_result(input logic op,
                                       input logic [TICK_W-1:0] start_tick,
                                       input logic [TICK_W-1:0] stop_tick,
                                       input logic [TICK_W-1:0] wraps,
                                       output filter_result_t r);
    r = '0;
    if (op == OP_RESTART) begin
      fill_q   = 0;
      median_q = '0;
    end else begin
      r.distance = capture_distance(start_tick, stop_tick, wraps, speed_q);
      if (fill_q >= WINDOW_SIZE) fill_q = 0;
      window_q[fill_q] = r.distance;
      fill_q++;
      if (fill_q >= WINDOW_SIZE) begin
        median_q = window_median();
        r.ready  = 1'b1;
        fill_q   = 0;
      end
    end
    r.median = median_q;
  endtask

  task automatic check_field(input string field, input logic [DIST_W-1:0] want,
                             input logic [DIST_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // watch config writes and both channels
  always @(posedge clk_i or negedge rst_ni) begin : track
    filter_result_t want;
    filter_result_t fresh;
    if (!rst_ni) begin
      speed_q  = SPEED_RESET;
      fill_q   = 0;
      median_q = '0;
      expected_results.delete();
    end else begin
      // result transfer: compare with the oldest expectation
      if (res_i.valid === 1'b1 && res_i.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no capture outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("sample_distance_cm", want.distance, res_i.sample_distance_cm);
          check_field("median_cm", want.median, res_i.median_cm);
          check_field("median_ready", {{(DIST_W-1){1'b0}}, want.ready},
                      {{(DIST_W-1){1'b0}}, res_i.median_ready});
        end
      end
      if (cfg_we_i) speed_q = cfg_wdata_i;
      // capture transfer: predict its result
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) begin
        predict_filter_result(in_i.op, in_i.echo_start_tick, in_i.echo_end_tick,
                              in_i.overflow_count, fresh);
        expected_results.push_back(fresh);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: test/tb_echo_distance_median_filter_top.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, capture stimulus, receiver stalls and verdict for the filter
module tb_echo_distance_median_filter_top;
  import edmf_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned PHASE_ITEMS      = 375;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 48;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [SPEED_W-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;

  edmf_in_if  in_ch ();
  edmf_out_if out_ch ();

  echo_distance_median_filter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  edmf_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_i          (in_ch),
    .res_i         (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one capture and wait for its transfer; called and returns at a falling edge
  task automatic send_capture(input logic op, input logic [TICK_W-1:0] start_tick,
                              input logic [TICK_W-1:0] stop_tick,
                              input logic [TICK_W-1:0] wraps);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           = 1'b1;
    in_ch.op              = op;
    in_ch.echo_start_tick = start_tick;
    in_ch.echo_end_tick   = stop_tick;
    in_ch.overflow_count  = wraps;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly samples with varied overflow counts, now and then a restart
  task automatic send_random_capture();
    logic [TICK_W-1:0] wraps;
    case ($urandom_range(3))
      0: wraps = '0;
      1: wraps = TICK_W'($urandom_range(3));
      2: wraps = TICK_W'($urandom_range(255));
      default: wraps = TICK_W'($urandom);
    endcase
    send_capture(($urandom_range(19) == 0) ? OP_RESTART : OP_SAMPLE,
                 TICK_W'($urandom), TICK_W'($urandom), wraps);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_speed(input logic [SPEED_W-1:0] speed);
    cfg_we    = 1'b1;
    cfg_wdata = speed;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.op              = OP_SAMPLE;
    in_ch.echo_start_tick = '0;
    in_ch.echo_end_tick   = '0;
    in_ch.overflow_count  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: tick extremes and wrap at the reset speed, window completes on the fifth
    send_capture(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
    send_capture(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'h0000);
    send_capture(OP_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000);
    send_capture(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_capture(OP_SAMPLE, 16'h8000, 16'h7FFF, 16'h0001);
    // restart in the middle of a window
    send_capture(OP_SAMPLE, 16'd100, 16'd5000, 16'h0000);
    send_capture(OP_SAMPLE, 16'hAAAA, 16'h5555, 16'h5555);
    send_capture(OP_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // unsorted window, then restart right after the median
    send_capture(OP_SAMPLE, 16'd0, 16'd30000, 16'h0000);
    send_capture(OP_SAMPLE, 16'd0, 16'd10000, 16'h0000);
    send_capture(OP_SAMPLE, 16'd0, 16'd50000, 16'h0000);
    send_capture(OP_SAMPLE, 16'd0, 16'd20000, 16'h0000);
    send_capture(OP_SAMPLE, 16'd0, 16'd40000, 16'h0000);
    send_capture(OP_RESTART, 16'h0000, 16'h0000, 16'h0000);
    // zero speed gives zero distance
    wait_idle();
    write_speed('0);
    send_capture(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_capture(OP_SAMPLE, 16'h1234, 16'hFEDC, 16'h0007);
    // highest speed, overflowing product
    wait_idle();
    write_speed({SPEED_W{1'b1}});
    send_capture(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_capture(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'h0000);
    send_capture(OP_SAMPLE, 16'hFFFF, 16'h0000, 16'h0001);
    send_capture(OP_SAMPLE, 16'h0001, 16'h0000, 16'h0000);
    send_capture(OP_SAMPLE, 16'h0400, 16'h0C00, 16'h0002);

    // random phases, each at its own speed and idling mix
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_speed(SPEED_W'(1));
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          write_speed(SPEED_W'($urandom_range(1023, 1)));
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          write_speed({SPEED_W{1'b1}});
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          write_speed(SPEED_W'($urandom_range(1023, 1)));
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_capture();
    end

    // drain and give the verdict
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/edmf_pkg.sv
src/edmf_if.sv
src/edmf_dist.sv
src/edmf_window.sv
src/echo_distance_median_filter_top.sv
src/edmf_checker.sv
test/edmf_result_checker.sv
test/tb_echo_distance_median_filter_top.sv
